[rtl/hthq_pkg.sv]
package hthq_pkg;

  localparam int DEF_MAX_VERTS_X = 256;
  localparam int DEF_MAX_VERTS_Z = 256;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int POS_W     = 24;
  localparam int INDEX_W   = 16;
  localparam int SAMPLE_W  = 8;
  localparam int HEIGHT_W  = 21;
  localparam int VERTS_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH   = 4;

  localparam logic [VERTS_W-1:0] VERTS_RESET = 9'd256;
  localparam logic [VERTS_W-1:0] VERTS_MIN   = 9'd2;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_QUERY,
    KIND_OFFGRID
  } item_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTS_X = 1'b0,
    REG_VERTS_Z = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One step of long division by ten: remainder so far and the next four bits
  // in, quotient digit and new remainder out.
  function automatic logic [7:0] div10_step(input logic [3:0] rem, input logic [3:0] nib);
    logic [7:0]  v;
    logic [15:0] t;
    logic [3:0]  q;
    logic [7:0]  r;
    v = {rem, nib};
    t = 16'(v) * 16'd205;
    q = t[14:11];
    r = v - (8'(q) * 8'd10);
    return {q, r[3:0]};
  endfunction

endpackage

[rtl/hthq_fifo.sv]
module hthq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hthq_pkg::Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    head_data,
  output hthq_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_data    = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/hthq_front.sv]
module hthq_front #(
  parameter int MAX_VERTS_X = hthq_pkg::DEF_MAX_VERTS_X,
  parameter int MAX_VERTS_Z = hthq_pkg::DEF_MAX_VERTS_Z,
  parameter int FRAC_BITS   = hthq_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [hthq_pkg::INDEX_W-1:0]        in_sample_index,
  input  logic [hthq_pkg::SAMPLE_W-1:0]       in_sample_height,
  input  logic [hthq_pkg::POS_W-1:0]          in_pos_x,
  input  logic [hthq_pkg::POS_W-1:0]          in_pos_z,
  input  logic [hthq_pkg::VERTS_W-1:0]        vx,
  input  logic [hthq_pkg::VERTS_W-1:0]        vz,
  input  hthq_pkg::q_status_t                 q_status,
  output logic                                push,
  output hthq_pkg::item_kind_t                f_kind,
  output logic [$clog2(MAX_VERTS_X*MAX_VERTS_Z)-1:0] f_base,
  output logic [((hthq_pkg::POS_W > FRAC_BITS) ? hthq_pkg::POS_W - FRAC_BITS : 1)-1:0] f_cx,
  output logic [hthq_pkg::SAMPLE_W-1:0]       f_sample,
  output logic                                f_upper,
  output logic [FRAC_BITS:0]                  f_wa,
  output logic [FRAC_BITS:0]                  f_wb,
  output logic [FRAC_BITS:0]                  f_wc
);

  localparam int unsigned STORE_DEPTH = MAX_VERTS_X * MAX_VERTS_Z;
  localparam int ADDR_W = $clog2(MAX_VERTS_X * MAX_VERTS_Z);
  localparam int CI_W   = (hthq_pkg::POS_W > FRAC_BITS) ? hthq_pkg::POS_W - FRAC_BITS : 1;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int PROD_W = CI_W + hthq_pkg::VERTS_W;
  localparam int CMP_W  = ((CI_W > hthq_pkg::VERTS_W) ? CI_W : hthq_pkg::VERTS_W) + 1;
  localparam logic [W_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                 f_valid_r, f_valid_nxt;
  logic                 advance;
  hthq_pkg::item_kind_t kind_nxt, f_kind_r;
  logic [ADDR_W-1:0]    base_nxt, f_base_r;
  logic [CI_W-1:0]      cx_nxt, f_cx_r;
  logic                 upper_nxt, f_upper_r;
  logic [W_W-1:0]       wa_nxt, wb_nxt, wc_nxt, f_wa_r, f_wb_r, f_wc_r;
  logic [hthq_pkg::SAMPLE_W-1:0] f_sample_r;
  logic [CI_W-1:0]      cx, cz;
  logic [W_W-1:0]       u, w, sum_uw;
  logic [PROD_W-1:0]    row_base;
  logic                 off_grid, in_range;

  assign in_stall = f_valid_r && q_status.full;
  assign push     = f_valid_r && !q_status.full;
  assign advance  = !f_valid_r || !q_status.full;

  assign cx       = CI_W'(in_pos_x >> FRAC_BITS);
  assign cz       = CI_W'(in_pos_z >> FRAC_BITS);
  assign u        = W_W'(in_pos_x[FRAC_BITS-1:0]);
  assign w        = W_W'(in_pos_z[FRAC_BITS-1:0]);
  assign sum_uw   = u + w;
  assign row_base = PROD_W'(cz) * PROD_W'(vx);
  assign off_grid = (CMP_W'(cx) >= (CMP_W'(vx) - 1'b1)) ||
                    (CMP_W'(cz) >= (CMP_W'(vz) - 1'b1));
  assign in_range = {16'b0, in_sample_index} < STORE_DEPTH;

  always_comb begin
    upper_nxt = (sum_uw > ONE);
    if (upper_nxt) begin
      wa_nxt = ONE - u;
      wb_nxt = ONE - w;
      wc_nxt = sum_uw - ONE;
    end else begin
      wa_nxt = ONE - sum_uw;
      wb_nxt = u;
      wc_nxt = w;
    end
    if (!in_mode) begin
      kind_nxt = in_range ? hthq_pkg::KIND_LOAD : hthq_pkg::KIND_NOP;
      base_nxt = ADDR_W'(in_sample_index);
      cx_nxt   = '0;
    end else begin
      kind_nxt = off_grid ? hthq_pkg::KIND_OFFGRID : hthq_pkg::KIND_QUERY;
      base_nxt = ADDR_W'(row_base);
      cx_nxt   = cx;
    end
  end

  assign f_valid_nxt = advance ? in_valid : f_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      f_kind_r   <= kind_nxt;
      f_base_r   <= base_nxt;
      f_cx_r     <= cx_nxt;
      f_sample_r <= in_sample_height;
      f_upper_r  <= upper_nxt;
      f_wa_r     <= wa_nxt;
      f_wb_r     <= wb_nxt;
      f_wc_r     <= wc_nxt;
    end
  end

  assign f_kind   = f_kind_r;
  assign f_base   = f_base_r;
  assign f_cx     = f_cx_r;
  assign f_sample = f_sample_r;
  assign f_upper  = f_upper_r;
  assign f_wa     = f_wa_r;
  assign f_wb     = f_wb_r;
  assign f_wc     = f_wc_r;

endmodule

[rtl/hthq_back.sv]
module hthq_back #(
  parameter int MAX_VERTS_X = hthq_pkg::DEF_MAX_VERTS_X,
  parameter int MAX_VERTS_Z = hthq_pkg::DEF_MAX_VERTS_Z,
  parameter int FRAC_BITS   = hthq_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [hthq_pkg::VERTS_W-1:0]        vx,
  input  hthq_pkg::q_status_t                 q_status,
  output logic                                pop,
  input  hthq_pkg::item_kind_t                h_kind,
  input  logic [$clog2(MAX_VERTS_X*MAX_VERTS_Z)-1:0] h_base,
  input  logic [((hthq_pkg::POS_W > FRAC_BITS) ? hthq_pkg::POS_W - FRAC_BITS : 1)-1:0] h_cx,
  input  logic [hthq_pkg::SAMPLE_W-1:0]       h_sample,
  input  logic                                h_upper,
  input  logic [FRAC_BITS:0]                  h_wa,
  input  logic [FRAC_BITS:0]                  h_wb,
  input  logic [FRAC_BITS:0]                  h_wc,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hthq_pkg::HEIGHT_W-1:0]       out_height,
  output logic                                out_out_of_grid
);

  localparam int DEPTH  = MAX_VERTS_X * MAX_VERTS_Z;
  localparam int ADDR_W = $clog2(MAX_VERTS_X * MAX_VERTS_Z);
  localparam int SW     = hthq_pkg::SAMPLE_W;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int P_W    = FRAC_BITS + SW;
  localparam int NIB    = (P_W + 3) / 4;
  localparam int YP_W   = 4 * NIB;
  localparam int NH     = (NIB + 1) / 2;
  localparam int NL     = NIB - NH;

  logic en;

  logic [SW-1:0] store_a_r [DEPTH];
  logic [SW-1:0] store_b_r [DEPTH];

  logic                 s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;
  hthq_pkg::item_kind_t s1_kind_r, s2_kind_r, s3_kind_r, s4_kind_r, s5_kind_r, s6_kind_r;
  logic [ADDR_W-1:0]    bl_nxt, br_nxt, tl_nxt, tr_nxt;
  logic [ADDR_W-1:0]    s1_bl_r, s1_br_r, s1_tl_r, s1_tr_r;
  logic [SW-1:0]        s1_sample_r;
  logic                 s1_upper_r, s2_upper_r;
  logic [W_W-1:0]       s1_wa_r, s1_wb_r, s1_wc_r, s2_wa_r, s2_wb_r, s2_wc_r;
  logic [SW-1:0]        rd_bl_r, rd_br_r, rd_tl_r, rd_tr_r;
  logic [SW-1:0]        ha, hb, hc;
  logic [SW+W_W-1:0]    pa_full, pb_full, pc_full;
  logic [P_W-1:0]       s3_pa_r, s3_pb_r, s3_pc_r;
  logic [P_W-1:0]       s4_y_r;
  logic [YP_W-1:0]      yp;
  logic [7:0]           st_hi, st_lo;
  logic [3:0]           rem_hi, rem_lo;
  logic [4*NH-1:0]      qh_nxt, s5_qh_r;
  logic [3:0]           s5_rem_r;
  logic [4*NL-1:0]      s5_lo_r, ql;
  logic [YP_W-1:0]      q_all;
  logic [YP_W-1:0]      s6_q_r;
  logic                 out_valid_r;
  logic [hthq_pkg::HEIGHT_W-1:0] out_height_r;
  logic                 out_off_r;

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !q_status.empty;

  assign bl_nxt = h_base + ADDR_W'(h_cx);
  assign br_nxt = h_base + ADDR_W'(h_cx) + 1'b1;
  assign tl_nxt = h_base + ADDR_W'(vx) + ADDR_W'(h_cx);
  assign tr_nxt = h_base + ADDR_W'(vx) + ADDR_W'(h_cx) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= !q_status.empty;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= s6_valid_r && ((s6_kind_r == hthq_pkg::KIND_QUERY) ||
                                    (s6_kind_r == hthq_pkg::KIND_OFFGRID));
    end
  end

  // Two copies of the height store, each written by every load, so that the
  // four corners of a cell can be read in the same cycle.
  always_ff @(posedge clk) begin
    if (en && s1_valid_r && (s1_kind_r == hthq_pkg::KIND_LOAD)) begin
      store_a_r[s1_bl_r] <= s1_sample_r;
    end
    if (en) begin
      rd_bl_r <= store_a_r[s1_bl_r];
      rd_br_r <= store_a_r[s1_br_r];
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r && (s1_kind_r == hthq_pkg::KIND_LOAD)) begin
      store_b_r[s1_bl_r] <= s1_sample_r;
    end
    if (en) begin
      rd_tl_r <= store_b_r[s1_tl_r];
      rd_tr_r <= store_b_r[s1_tr_r];
    end
  end

  always_comb begin
    if (s2_upper_r) begin
      ha = rd_tl_r;
      hb = rd_br_r;
      hc = rd_tr_r;
    end else begin
      ha = rd_bl_r;
      hb = rd_br_r;
      hc = rd_tl_r;
    end
  end

  assign pa_full = ha * s2_wa_r;
  assign pb_full = hb * s2_wb_r;
  assign pc_full = hc * s2_wc_r;

  always_comb begin
    yp     = YP_W'(s4_y_r);
    rem_hi = '0;
    qh_nxt = '0;
    st_hi  = '0;
    for (int i = 0; i < NH; i++) begin
      st_hi = hthq_pkg::div10_step(rem_hi, yp[YP_W-1-4*i -: 4]);
      qh_nxt[4*(NH-1-i) +: 4] = st_hi[7:4];
      rem_hi = st_hi[3:0];
    end
  end

  always_comb begin
    rem_lo = s5_rem_r;
    ql     = '0;
    st_lo  = '0;
    for (int i = 0; i < NL; i++) begin
      st_lo = hthq_pkg::div10_step(rem_lo, s5_lo_r[4*NL-1-4*i -: 4]);
      ql[4*(NL-1-i) +: 4] = st_lo[7:4];
      rem_lo = st_lo[3:0];
    end
  end

  assign q_all = {s5_qh_r, ql};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r   <= h_kind;
      s1_bl_r     <= bl_nxt;
      s1_br_r     <= br_nxt;
      s1_tl_r     <= tl_nxt;
      s1_tr_r     <= tr_nxt;
      s1_sample_r <= h_sample;
      s1_upper_r  <= h_upper;
      s1_wa_r     <= h_wa;
      s1_wb_r     <= h_wb;
      s1_wc_r     <= h_wc;
      s2_kind_r   <= s1_kind_r;
      s2_upper_r  <= s1_upper_r;
      s2_wa_r     <= s1_wa_r;
      s2_wb_r     <= s1_wb_r;
      s2_wc_r     <= s1_wc_r;
      s3_kind_r   <= s2_kind_r;
      s3_pa_r     <= P_W'(pa_full);
      s3_pb_r     <= P_W'(pb_full);
      s3_pc_r     <= P_W'(pc_full);
      s4_kind_r   <= s3_kind_r;
      s4_y_r      <= s3_pa_r + s3_pb_r + s3_pc_r + P_W'(5);
      s5_kind_r   <= s4_kind_r;
      s5_qh_r     <= qh_nxt;
      s5_rem_r    <= rem_hi;
      s5_lo_r     <= yp[4*NL-1:0];
      s6_kind_r   <= s5_kind_r;
      out_off_r   <= (s6_kind_r == hthq_pkg::KIND_OFFGRID);
      out_height_r <= (s6_kind_r == hthq_pkg::KIND_OFFGRID) ? '0 :
                      hthq_pkg::HEIGHT_W'(s6_q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q_r <= q_all;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_height      = out_height_r;
  assign out_out_of_grid = out_off_r;

endmodule

[rtl/heightmap_triangle_height_query.sv]
// Terrain height lookup over a grid of 8-bit height samples.
// Input channel (in_valid/in_stall): in_mode low loads in_sample_height at grid
// index in_sample_index and gives no result; in_mode high queries the height at
// (in_pos_x, in_pos_z) and gives exactly one result transaction on the output
// channel (out_valid/out_stall) carrying out_height and out_out_of_grid.
// Results leave in the order in which their queries were accepted.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the grid size in
// use; cfg_ready is always high. Writes are to be made only while the block is
// idle; the block itself does not enforce this. One transaction is taken every
// cycle while in_stall is low. A query passes the front stage, the queue, the
// address stage, the registered read of the two copies of the height store, the
// weighting multipliers, the sum and two stages of division by ten. A load is
// visible to every later query. Reset clears the pipeline and sets both grid
// sizes to 256; stored samples are undefined until loaded. While out_stall is high
// and a result is shown, the back pipeline holds, a four-entry queue behind the
// classifying front stage fills, and in_stall rises only once that queue is full.
module heightmap_triangle_height_query #(
  parameter int MAX_VERTS_X = hthq_pkg::DEF_MAX_VERTS_X,
  parameter int MAX_VERTS_Z = hthq_pkg::DEF_MAX_VERTS_Z,
  parameter int FRAC_BITS   = hthq_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [hthq_pkg::INDEX_W-1:0]     in_sample_index,
  input  logic [hthq_pkg::SAMPLE_W-1:0]    in_sample_height,
  input  logic [hthq_pkg::POS_W-1:0]       in_pos_x,
  input  logic [hthq_pkg::POS_W-1:0]       in_pos_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hthq_pkg::HEIGHT_W-1:0]    out_height,
  output logic                             out_out_of_grid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hthq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hthq_pkg::VERTS_W-1:0]     cfg_data
);

  localparam int ADDR_W  = $clog2(MAX_VERTS_X * MAX_VERTS_Z);
  localparam int CI_W    = (hthq_pkg::POS_W > FRAC_BITS) ? hthq_pkg::POS_W - FRAC_BITS : 1;
  localparam int W_W     = FRAC_BITS + 1;
  localparam int ENTRY_W = 2 + ADDR_W + CI_W + hthq_pkg::SAMPLE_W + 1 + 3 * W_W;
  localparam int VW      = hthq_pkg::VERTS_W;

  logic [VW-1:0] verts_x_r, verts_z_r;
  logic [VW-1:0] vx, vz;

  hthq_pkg::q_status_t  q_stat;
  logic                 push, pop;
  hthq_pkg::item_kind_t f_kind, h_kind;
  logic [ADDR_W-1:0]    f_base, h_base;
  logic [CI_W-1:0]      f_cx, h_cx;
  logic [hthq_pkg::SAMPLE_W-1:0] f_sample, h_sample;
  logic                 f_upper, h_upper;
  logic [W_W-1:0]       f_wa, f_wb, f_wc, h_wa, h_wb, h_wc;
  logic [ENTRY_W-1:0]   push_data, head_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verts_x_r <= hthq_pkg::VERTS_RESET;
      verts_z_r <= hthq_pkg::VERTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (hthq_pkg::cfg_reg_t'(cfg_index))
        hthq_pkg::REG_VERTS_X: verts_x_r <= cfg_data;
        hthq_pkg::REG_VERTS_Z: verts_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (verts_x_r < hthq_pkg::VERTS_MIN) begin
      vx = hthq_pkg::VERTS_MIN;
    end else if (32'(verts_x_r) > MAX_VERTS_X) begin
      vx = VW'(MAX_VERTS_X);
    end else begin
      vx = verts_x_r;
    end
    if (verts_z_r < hthq_pkg::VERTS_MIN) begin
      vz = hthq_pkg::VERTS_MIN;
    end else if (32'(verts_z_r) > MAX_VERTS_Z) begin
      vz = VW'(MAX_VERTS_Z);
    end else begin
      vz = verts_z_r;
    end
  end

  hthq_front #(
    .MAX_VERTS_X (MAX_VERTS_X),
    .MAX_VERTS_Z (MAX_VERTS_Z),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_sample_index  (in_sample_index),
    .in_sample_height (in_sample_height),
    .in_pos_x         (in_pos_x),
    .in_pos_z         (in_pos_z),
    .vx               (vx),
    .vz               (vz),
    .q_status         (q_stat),
    .push             (push),
    .f_kind           (f_kind),
    .f_base           (f_base),
    .f_cx             (f_cx),
    .f_sample         (f_sample),
    .f_upper          (f_upper),
    .f_wa             (f_wa),
    .f_wb             (f_wb),
    .f_wc             (f_wc)
  );

  assign push_data = {f_kind, f_base, f_cx, f_sample, f_upper, f_wa, f_wb, f_wc};

  hthq_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (hthq_pkg::Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_stat)
  );

  assign h_kind = hthq_pkg::item_kind_t'(head_data[ENTRY_W-1 -: 2]);
  assign {h_base, h_cx, h_sample, h_upper, h_wa, h_wb, h_wc} = head_data[ENTRY_W-3:0];

  hthq_back #(
    .MAX_VERTS_X (MAX_VERTS_X),
    .MAX_VERTS_Z (MAX_VERTS_Z),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .vx              (vx),
    .q_status        (q_stat),
    .pop             (pop),
    .h_kind          (h_kind),
    .h_base          (h_base),
    .h_cx            (h_cx),
    .h_sample        (h_sample),
    .h_upper         (h_upper),
    .h_wa            (h_wa),
    .h_wb            (h_wb),
    .h_wc            (h_wc),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_height      (out_height),
    .out_out_of_grid (out_out_of_grid)
  );

  a_offgrid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_grid) |-> (out_height == '0))
    else $error("off-grid result carries a non-zero height");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full)
    else $error("input stalled while the queue has room");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule
